// File: rtl/core/tbp_pkg.sv
// Shared types, constants and a helper function of the tournament branch predictor.
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

   localparam int unsigned PC_WIDTH         = 32;
   localparam int unsigned PC_WORD_WIDTH    = PC_WIDTH - 2;
   localparam int unsigned HIST_FIELD_WIDTH = 8;
   localparam int unsigned CTR_WIDTH        = 2;
   localparam int unsigned ROW_WIDTH        = 2 * CTR_WIDTH;

   localparam logic [PC_WIDTH-1:0]  PC_STEP = 32'd4;
   localparam logic [CTR_WIDTH-1:0] CTR_MAX = 2'd3;
   localparam logic [CTR_WIDTH-1:0] CTR_MIN = 2'd0;

   localparam int unsigned PHT_INDEX_BITS_DEF     = 10;
   localparam int unsigned CHOOSER_INDEX_BITS_DEF = 10;
   localparam int unsigned BTB_INDEX_BITS_DEF     = 10;
   localparam int unsigned SEEN_INDEX_BITS_DEF    = 10;
   localparam int unsigned HISTORY_BITS_DEF       = 8;

   typedef enum logic [1:0] {
      KIND_PREDICT      = 2'd0,
      KIND_RESOLVE_COND = 2'd1,
      KIND_RESOLVE_JUMP = 2'd2,
      KIND_RESTORE      = 2'd3
   } kind_type;

   typedef struct packed {
      logic                valid;
      logic [PC_WIDTH-1:0] tag;
      logic [PC_WIDTH-1:0] target;
      logic                uncond;
      logic                ret;
   } btb_entry_type;

   localparam int unsigned BTB_ENTRY_WIDTH = $bits(btb_entry_type);

   typedef struct packed {
      logic                        pred_taken;
      logic [PC_WIDTH-1:0]         next_pc;
      logic                        btb_hit;
      logic                        is_uncond;
      logic [HIST_FIELD_WIDTH-1:0] history_before;
   } rsp_type;

   typedef struct packed {
      logic                 hist_we;
      logic                 local_we;
      logic                 global_we;
      logic                 chooser_we;
      logic                 seen_we;
      logic                 btb_we;
      logic [CTR_WIDTH-1:0] local_ctr;
      logic [ROW_WIDTH-1:0] global_row;
      logic [ROW_WIDTH-1:0] chooser_row;
      btb_entry_type        btb_entry;
   } upd_type;

   function automatic logic [CTR_WIDTH-1:0] sat_move(input logic [CTR_WIDTH-1:0] ctr,
                                                      input logic up);
      logic [CTR_WIDTH-1:0] result;
      if (up) begin
         result = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
      end else begin
         result = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tournament_branch_predictor_unit.sv
// Top level of the tournament branch predictor with its branch target buffer.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         req_valid, req_stall  kind, pc, taken, target, history,
//                                              is_ret, ras_valid, ras_addr
//   rsp_*     out        rsp_valid, rsp_stall  pred_taken, next_pc, btb_hit,
//                                              is_uncond, history_before
//
// One item is taken per cycle unless req_stall is high; its result passes
// through the working stage and then the output register. Table reads are
// issued from the input ports, and the second read port of the gshare and
// chooser tables covers a history shift by the item ahead. After reset a
// clearing pass zeroes every table entry, and req_stall stays high during it.
// req_stall is also high while the working stage holds an item that the
// stalled output register cannot take. Table sizes are 2**(index bits) entries.
`timescale 1ns / 1ps
`default_nettype none

module tournament_branch_predictor_unit #(
   parameter int unsigned PHT_INDEX_BITS     = tbp_pkg::PHT_INDEX_BITS_DEF,
   parameter int unsigned CHOOSER_INDEX_BITS = tbp_pkg::CHOOSER_INDEX_BITS_DEF,
   parameter int unsigned BTB_INDEX_BITS     = tbp_pkg::BTB_INDEX_BITS_DEF,
   parameter int unsigned SEEN_INDEX_BITS    = tbp_pkg::SEEN_INDEX_BITS_DEF,
   parameter int unsigned HISTORY_BITS       = tbp_pkg::HISTORY_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_kind,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]         req_pc,
   input  wire logic                                 req_taken,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]         req_target,
   input  wire logic [tbp_pkg::HIST_FIELD_WIDTH-1:0] req_history,
   input  wire logic                                 req_is_ret,
   input  wire logic                                 req_ras_valid,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]         req_ras_addr,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_pred_taken,
   output logic      [tbp_pkg::PC_WIDTH-1:0]         rsp_next_pc,
   output logic                                      rsp_btb_hit,
   output logic                                      rsp_is_uncond,
   output logic      [tbp_pkg::HIST_FIELD_WIDTH-1:0] rsp_history_before
);

   localparam int unsigned WORD_WIDTH = tbp_pkg::PC_WORD_WIDTH;
   localparam int unsigned PHT_ROW_BITS = PHT_INDEX_BITS - 1;
   localparam int unsigned CHO_ROW_BITS = CHOOSER_INDEX_BITS - 1;
   localparam int unsigned MAX_A = (PHT_INDEX_BITS > CHOOSER_INDEX_BITS) ?
                                   PHT_INDEX_BITS : CHOOSER_INDEX_BITS;
   localparam int unsigned MAX_B = (BTB_INDEX_BITS > SEEN_INDEX_BITS) ?
                                   BTB_INDEX_BITS : SEEN_INDEX_BITS;
   localparam int unsigned CLEAR_BITS = (MAX_A > MAX_B) ? MAX_A : MAX_B;

   // Handshake and clearing control.
   logic                  accept;
   logic                  advance;
   logic                  clear_active_ff;
   logic                  clear_active_in;
   logic [CLEAR_BITS-1:0] clear_cnt_ff;
   logic [CLEAR_BITS-1:0] clear_cnt_in;

   // Working stage.
   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   tbp_pkg::kind_type                 s1_kind_ff;
   logic [tbp_pkg::PC_WIDTH-1:0]      s1_pc_ff;
   logic                              s1_taken_ff;
   logic [tbp_pkg::PC_WIDTH-1:0]      s1_target_ff;
   logic [HISTORY_BITS-1:0]           s1_hist_ff;
   logic                              s1_is_ret_ff;
   logic                              s1_ras_valid_ff;
   logic [tbp_pkg::PC_WIDTH-1:0]      s1_ras_addr_ff;
   logic [PHT_ROW_BITS-1:0]           s1_global_row_ff;
   logic [CHO_ROW_BITS-1:0]           s1_chooser_row_ff;
   logic [WORD_WIDTH-1:0]             s1_word;

   logic [HISTORY_BITS-1:0]           history_ff;
   logic [HISTORY_BITS-1:0]           history_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   tbp_pkg::rsp_type                  rsp_data_ff;

   // Read side.
   tbp_pkg::kind_type                 req_kind_cast;
   logic [WORD_WIDTH-1:0]             req_word;
   logic [HISTORY_BITS-1:0]           req_hist;
   logic [HISTORY_BITS-1:0]           hist_known;
   logic [HISTORY_BITS-1:0]           hist_port_a;
   logic [HISTORY_BITS-1:0]           hist_port_b;
   logic [WORD_WIDTH-1:0]             index_a;
   logic [WORD_WIDTH-1:0]             index_b;

   logic [tbp_pkg::CTR_WIDTH-1:0]     local_rd;
   logic [tbp_pkg::ROW_WIDTH-1:0]     global_rd_a;
   logic [tbp_pkg::ROW_WIDTH-1:0]     global_rd_b;
   logic [tbp_pkg::ROW_WIDTH-1:0]     chooser_rd_a;
   logic [tbp_pkg::ROW_WIDTH-1:0]     chooser_rd_b;
   logic [tbp_pkg::BTB_ENTRY_WIDTH-1:0] btb_rd;
   logic                              seen_rd;

   // Write side.
   tbp_pkg::rsp_type                  rsp_next;
   tbp_pkg::upd_type                  upd;
   logic [HISTORY_BITS-1:0]           hist_next;
   logic [PHT_INDEX_BITS-1:0]         global_idx;
   logic [CHOOSER_INDEX_BITS-1:0]     chooser_idx;

   logic                              local_we;
   logic [PHT_INDEX_BITS-1:0]         local_waddr;
   logic [tbp_pkg::CTR_WIDTH-1:0]     local_wdata;
   logic                              global_we;
   logic [PHT_ROW_BITS-1:0]           global_waddr;
   logic [tbp_pkg::ROW_WIDTH-1:0]     global_wdata;
   logic                              chooser_we;
   logic [CHO_ROW_BITS-1:0]           chooser_waddr;
   logic [tbp_pkg::ROW_WIDTH-1:0]     chooser_wdata;
   logic                              btb_we;
   logic [BTB_INDEX_BITS-1:0]         btb_waddr;
   logic [tbp_pkg::BTB_ENTRY_WIDTH-1:0] btb_wdata;
   logic                              seen_we;
   logic [SEEN_INDEX_BITS-1:0]        seen_waddr;
   logic                              seen_wdata;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || clear_active_ff || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_cnt_in    = clear_cnt_ff;
      if (clear_active_ff) begin
         clear_cnt_in = clear_cnt_ff + CLEAR_BITS'(1);
         if (clear_cnt_ff == {CLEAR_BITS{1'b1}}) begin
            clear_active_in = 1'b0;
         end
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign history_in   = (advance && upd.hist_we) ? hist_next : history_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_cnt_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         history_ff      <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_cnt_ff    <= clear_cnt_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         history_ff      <= history_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff        <= req_kind_cast;
         s1_pc_ff          <= req_pc;
         s1_taken_ff       <= req_taken;
         s1_target_ff      <= req_target;
         s1_hist_ff        <= req_hist;
         s1_is_ret_ff      <= req_is_ret;
         s1_ras_valid_ff   <= req_ras_valid;
         s1_ras_addr_ff    <= req_ras_addr;
         s1_global_row_ff  <= index_a[PHT_INDEX_BITS-1:1];
         s1_chooser_row_ff <= index_a[CHOOSER_INDEX_BITS-1:1];
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // The history an issuing item sees is known except for the shift of a
   // prediction still in the working stage, which the second port covers.
   assign req_kind_cast = tbp_pkg::kind_type'(req_kind);
   assign req_word      = req_pc[tbp_pkg::PC_WIDTH-1:2];
   assign req_hist      = HISTORY_BITS'(req_history);
   assign hist_known    = (s1_valid_ff && (s1_kind_ff == tbp_pkg::KIND_RESTORE)) ?
                          s1_hist_ff : history_ff;
   assign hist_port_a   = (req_kind_cast == tbp_pkg::KIND_RESOLVE_COND) ?
                          req_hist : hist_known;
   assign hist_port_b   = HISTORY_BITS'({history_ff, 1'b0});
   assign index_a       = req_word ^ WORD_WIDTH'(hist_port_a);
   assign index_b       = req_word ^ WORD_WIDTH'(hist_port_b);
   assign s1_word       = s1_pc_ff[tbp_pkg::PC_WIDTH-1:2];

   always_comb begin
      if (clear_active_ff) begin
         local_we      = 1'b1;
         local_waddr   = clear_cnt_ff[PHT_INDEX_BITS-1:0];
         local_wdata   = '0;
         global_we     = 1'b1;
         global_waddr  = clear_cnt_ff[PHT_ROW_BITS-1:0];
         global_wdata  = '0;
         chooser_we    = 1'b1;
         chooser_waddr = clear_cnt_ff[CHO_ROW_BITS-1:0];
         chooser_wdata = '0;
         btb_we        = 1'b1;
         btb_waddr     = clear_cnt_ff[BTB_INDEX_BITS-1:0];
         btb_wdata     = '0;
         seen_we       = 1'b1;
         seen_waddr    = clear_cnt_ff[SEEN_INDEX_BITS-1:0];
         seen_wdata    = 1'b0;
      end else begin
         local_we      = advance && upd.local_we;
         local_waddr   = s1_word[PHT_INDEX_BITS-1:0];
         local_wdata   = upd.local_ctr;
         global_we     = advance && upd.global_we;
         global_waddr  = global_idx[PHT_INDEX_BITS-1:1];
         global_wdata  = upd.global_row;
         chooser_we    = advance && upd.chooser_we;
         chooser_waddr = chooser_idx[CHOOSER_INDEX_BITS-1:1];
         chooser_wdata = upd.chooser_row;
         btb_we        = advance && upd.btb_we;
         btb_waddr     = s1_word[BTB_INDEX_BITS-1:0];
         btb_wdata     = upd.btb_entry;
         seen_we       = advance && upd.seen_we;
         seen_waddr    = s1_word[SEEN_INDEX_BITS-1:0];
         seen_wdata    = 1'b1;
      end
   end

   tbp_ram #(
      .WIDTH (tbp_pkg::CTR_WIDTH),
      .DEPTH (2 ** PHT_INDEX_BITS)
   ) u_local_ram (
      .clock     (clock),
      .wr_en     (local_we),
      .wr_addr   (local_waddr),
      .wr_data   (local_wdata),
      .rd_en     (accept),
      .rd_addr_a (req_word[PHT_INDEX_BITS-1:0]),
      .rd_data_a (local_rd),
      .rd_addr_b ('0),
      .rd_data_b ()
   );

   tbp_ram #(
      .WIDTH (tbp_pkg::ROW_WIDTH),
      .DEPTH (2 ** PHT_ROW_BITS)
   ) u_global_ram (
      .clock     (clock),
      .wr_en     (global_we),
      .wr_addr   (global_waddr),
      .wr_data   (global_wdata),
      .rd_en     (accept),
      .rd_addr_a (index_a[PHT_INDEX_BITS-1:1]),
      .rd_data_a (global_rd_a),
      .rd_addr_b (index_b[PHT_INDEX_BITS-1:1]),
      .rd_data_b (global_rd_b)
   );

   tbp_ram #(
      .WIDTH (tbp_pkg::ROW_WIDTH),
      .DEPTH (2 ** CHO_ROW_BITS)
   ) u_chooser_ram (
      .clock     (clock),
      .wr_en     (chooser_we),
      .wr_addr   (chooser_waddr),
      .wr_data   (chooser_wdata),
      .rd_en     (accept),
      .rd_addr_a (index_a[CHOOSER_INDEX_BITS-1:1]),
      .rd_data_a (chooser_rd_a),
      .rd_addr_b (index_b[CHOOSER_INDEX_BITS-1:1]),
      .rd_data_b (chooser_rd_b)
   );

   tbp_ram #(
      .WIDTH (tbp_pkg::BTB_ENTRY_WIDTH),
      .DEPTH (2 ** BTB_INDEX_BITS)
   ) u_btb_ram (
      .clock     (clock),
      .wr_en     (btb_we),
      .wr_addr   (btb_waddr),
      .wr_data   (btb_wdata),
      .rd_en     (accept),
      .rd_addr_a (req_word[BTB_INDEX_BITS-1:0]),
      .rd_data_a (btb_rd),
      .rd_addr_b ('0),
      .rd_data_b ()
   );

   tbp_ram #(
      .WIDTH (1),
      .DEPTH (2 ** SEEN_INDEX_BITS)
   ) u_seen_ram (
      .clock     (clock),
      .wr_en     (seen_we),
      .wr_addr   (seen_waddr),
      .wr_data   (seen_wdata),
      .rd_en     (accept),
      .rd_addr_a (req_word[SEEN_INDEX_BITS-1:0]),
      .rd_data_a (seen_rd),
      .rd_addr_b ('0),
      .rd_data_b ()
   );

   tbp_decide #(
      .PHT_INDEX_BITS     (PHT_INDEX_BITS),
      .CHOOSER_INDEX_BITS (CHOOSER_INDEX_BITS),
      .HISTORY_BITS       (HISTORY_BITS)
   ) u_decide (
      .kind               (s1_kind_ff),
      .pc                 (s1_pc_ff),
      .taken              (s1_taken_ff),
      .target             (s1_target_ff),
      .hist               (s1_hist_ff),
      .is_ret             (s1_is_ret_ff),
      .ras_valid          (s1_ras_valid_ff),
      .ras_addr           (s1_ras_addr_ff),
      .history            (history_ff),
      .local_ctr          (local_rd),
      .global_row_a       (global_rd_a),
      .global_row_b       (global_rd_b),
      .global_row_a_addr  (s1_global_row_ff),
      .chooser_row_a      (chooser_rd_a),
      .chooser_row_b      (chooser_rd_b),
      .chooser_row_a_addr (s1_chooser_row_ff),
      .btb_entry          (tbp_pkg::btb_entry_type'(btb_rd)),
      .seen               (seen_rd),
      .rsp                (rsp_next),
      .upd                (upd),
      .hist_next          (hist_next),
      .global_idx         (global_idx),
      .chooser_idx        (chooser_idx)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pred_taken     = rsp_data_ff.pred_taken;
   assign rsp_next_pc        = rsp_data_ff.next_pc;
   assign rsp_btb_hit        = rsp_data_ff.btb_hit;
   assign rsp_is_uncond      = rsp_data_ff.is_uncond;
   assign rsp_history_before = rsp_data_ff.history_before;

`ifndef SYNTHESIS
   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !s1_valid_ff)
      else $error("Working stage holds an item during the clearing pass.");

   a_non_predict_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_kind_ff != tbp_pkg::KIND_PREDICT)) |=> (rsp_data_ff == '0))
      else $error("Result of a non-predict transfer is not all zero.");

   a_resolve_keeps_history: assert property (@(posedge clock) disable iff (reset)
      (advance && ((s1_kind_ff == tbp_pkg::KIND_RESOLVE_COND) ||
                   (s1_kind_ff == tbp_pkg::KIND_RESOLVE_JUMP))) |=> $stable(history_ff))
      else $error("A resolve transfer changed the global history.");

   a_taken_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.pred_taken || rsp_data_ff.is_uncond))
         |-> rsp_data_ff.btb_hit)
      else $error("Taken or unconditional prediction without a target buffer hit.");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tbp_ram.sv
// Generic RAM with one write port and two registered write-first read ports.
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem_ff[rd_addr_a];
         rd_data_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// File: rtl/core/tbp_decide.sv
// Prediction and training logic that works on one registered item and its table reads.
`timescale 1ns / 1ps
`default_nettype none

module tbp_decide #(
   parameter int unsigned PHT_INDEX_BITS     = tbp_pkg::PHT_INDEX_BITS_DEF,
   parameter int unsigned CHOOSER_INDEX_BITS = tbp_pkg::CHOOSER_INDEX_BITS_DEF,
   parameter int unsigned HISTORY_BITS       = tbp_pkg::HISTORY_BITS_DEF
) (
   input  wire tbp_pkg::kind_type                  kind,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]       pc,
   input  wire logic                               taken,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]       target,
   input  wire logic [HISTORY_BITS-1:0]            hist,
   input  wire logic                               is_ret,
   input  wire logic                               ras_valid,
   input  wire logic [tbp_pkg::PC_WIDTH-1:0]       ras_addr,
   input  wire logic [HISTORY_BITS-1:0]            history,
   input  wire logic [tbp_pkg::CTR_WIDTH-1:0]      local_ctr,
   input  wire logic [tbp_pkg::ROW_WIDTH-1:0]      global_row_a,
   input  wire logic [tbp_pkg::ROW_WIDTH-1:0]      global_row_b,
   input  wire logic [PHT_INDEX_BITS-2:0]          global_row_a_addr,
   input  wire logic [tbp_pkg::ROW_WIDTH-1:0]      chooser_row_a,
   input  wire logic [tbp_pkg::ROW_WIDTH-1:0]      chooser_row_b,
   input  wire logic [CHOOSER_INDEX_BITS-2:0]      chooser_row_a_addr,
   input  wire tbp_pkg::btb_entry_type             btb_entry,
   input  wire logic                               seen,
   output tbp_pkg::rsp_type                        rsp,
   output tbp_pkg::upd_type                        upd,
   output logic      [HISTORY_BITS-1:0]            hist_next,
   output logic      [PHT_INDEX_BITS-1:0]          global_idx,
   output logic      [CHOOSER_INDEX_BITS-1:0]      chooser_idx
);

   localparam int unsigned WORD_WIDTH = tbp_pkg::PC_WORD_WIDTH;

   logic [WORD_WIDTH-1:0]             word;
   logic [HISTORY_BITS-1:0]           index_hist;
   logic [WORD_WIDTH-1:0]             gx;
   logic [tbp_pkg::ROW_WIDTH-1:0]     global_row;
   logic [tbp_pkg::ROW_WIDTH-1:0]     chooser_row;
   logic [tbp_pkg::CTR_WIDTH-1:0]     global_ctr;
   logic [tbp_pkg::CTR_WIDTH-1:0]     chooser_ctr;
   logic [tbp_pkg::CTR_WIDTH-1:0]     global_new;
   logic [tbp_pkg::CTR_WIDTH-1:0]     chooser_new;
   logic                              local_dir;
   logic                              global_dir;
   logic                              dir;
   logic                              hit_raw;
   logic                              hit;
   logic                              ptaken;
   logic [tbp_pkg::PC_WIDTH-1:0]      npc;
   logic                              shift_bit;
   logic [HISTORY_BITS-1:0]           hist_shifted;

   assign word       = pc[tbp_pkg::PC_WIDTH-1:2];
   assign index_hist = (kind == tbp_pkg::KIND_PREDICT) ? history : hist;
   assign gx         = word ^ WORD_WIDTH'(index_hist);
   assign global_idx  = gx[PHT_INDEX_BITS-1:0];
   assign chooser_idx = gx[CHOOSER_INDEX_BITS-1:0];

   // The first read port holds the row for the history seen at issue; the second
   // holds the row for a history that has shifted by one since then.
   assign global_row  = (global_idx[PHT_INDEX_BITS-1:1] == global_row_a_addr) ?
                        global_row_a : global_row_b;
   assign chooser_row = (chooser_idx[CHOOSER_INDEX_BITS-1:1] == chooser_row_a_addr) ?
                        chooser_row_a : chooser_row_b;
   assign global_ctr  = global_idx[0] ? global_row[3:2] : global_row[1:0];
   assign chooser_ctr = chooser_idx[0] ? chooser_row[3:2] : chooser_row[1:0];

   assign local_dir  = local_ctr[1];
   assign global_dir = global_ctr[1];
   assign dir        = chooser_ctr[1] ? global_dir : local_dir;

   // A return hit with an empty return stack counts as a miss.
   assign hit_raw = btb_entry.valid && (btb_entry.tag == pc);
   assign hit     = hit_raw && !(btb_entry.ret && !ras_valid);
   assign ptaken  = hit && (dir || btb_entry.uncond);
   assign npc     = !ptaken ? pc + tbp_pkg::PC_STEP :
                    (btb_entry.ret ? ras_addr : btb_entry.target);

   assign shift_bit    = hit && (btb_entry.uncond || ptaken);
   assign hist_shifted = HISTORY_BITS'({history, shift_bit});

   assign global_new = tbp_pkg::sat_move(global_ctr, taken);

   always_comb begin
      if ((global_dir == taken) && (local_dir != taken)) begin
         chooser_new = tbp_pkg::sat_move(chooser_ctr, 1'b1);
      end else if ((local_dir == taken) && (global_dir != taken)) begin
         chooser_new = tbp_pkg::sat_move(chooser_ctr, 1'b0);
      end else begin
         chooser_new = chooser_ctr;
      end
   end

   always_comb begin
      rsp       = '0;
      upd       = '0;
      hist_next = history;
      unique case (kind)
         tbp_pkg::KIND_PREDICT: begin
            rsp.pred_taken     = ptaken;
            rsp.next_pc        = npc;
            rsp.btb_hit        = hit;
            rsp.is_uncond      = hit && btb_entry.uncond;
            rsp.history_before = tbp_pkg::HIST_FIELD_WIDTH'(history);
            upd.hist_we        = hit || seen;
            hist_next          = hist_shifted;
         end
         tbp_pkg::KIND_RESOLVE_COND: begin
            upd.local_we          = 1'b1;
            upd.local_ctr         = tbp_pkg::sat_move(local_ctr, taken);
            upd.global_we         = 1'b1;
            upd.global_row        = global_idx[0] ? {global_new, global_row[1:0]} :
                                                    {global_row[3:2], global_new};
            upd.chooser_we        = 1'b1;
            upd.chooser_row       = chooser_idx[0] ? {chooser_new, chooser_row[1:0]} :
                                                     {chooser_row[3:2], chooser_new};
            upd.seen_we           = 1'b1;
            upd.btb_we            = taken;
            upd.btb_entry.valid   = 1'b1;
            upd.btb_entry.tag     = pc;
            upd.btb_entry.target  = target;
            upd.btb_entry.uncond  = 1'b0;
            upd.btb_entry.ret     = 1'b0;
         end
         tbp_pkg::KIND_RESOLVE_JUMP: begin
            upd.btb_we            = 1'b1;
            upd.btb_entry.valid   = 1'b1;
            upd.btb_entry.tag     = pc;
            upd.btb_entry.target  = target;
            upd.btb_entry.uncond  = 1'b1;
            upd.btb_entry.ret     = is_ret;
         end
         tbp_pkg::KIND_RESTORE: begin
            upd.hist_we = 1'b1;
            hist_next   = hist;
         end
         default: begin
            upd.hist_we = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire
